>>> rtl/core/cfd_pkg.sv
// Shared types and constants of the central FIFO task dispatcher.
package cfd_pkg;

   localparam int QUEUE_DEPTH  = 1024;
   localparam int WORKER_SLOTS = 8;
   localparam int QA_W         = $clog2(QUEUE_DEPTH);
   localparam int QC_W         = $clog2(QUEUE_DEPTH + 1);
   localparam int SLOT_W       = (WORKER_SLOTS > 1) ? $clog2(WORKER_SLOTS) : 1;
   localparam int SLOT_CW      = $clog2(WORKER_SLOTS + 1);
   localparam int HANDLE_W     = 64;
   localparam int ATTR_W       = 19;

   typedef enum logic [1:0] {
      CMD_ARRIVAL   = 2'd0,
      CMD_FINISHED  = 2'd1,
      CMD_PREEMPTED = 2'd2,
      CMD_SCAN      = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_DISPATCH = 2'd0,
      KIND_RELEASE  = 2'd1,
      KIND_PREEMPT  = 2'd2,
      KIND_DROPPED  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      CSR_WORKERS_IN_USE = 2'd0,
      CSR_PREEMPT_ENABLE = 2'd1,
      CSR_PREEMPT_DELAY  = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SLOT,
      ST_READ,
      ST_DISP,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [2:0]  worker_id;
      logic [31:0] task_handle;
      logic [31:0] buffer_handle;
      logic [15:0] task_type;
      logic [2:0]  task_category;
      logic [62:0] now;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  out_worker;
      logic [31:0] out_task;
      logic [31:0] out_buffer;
      logic [15:0] out_type;
      logic [2:0]  out_category;
      logic [62:0] start_stamp;
      logic        last;
   } rsp_type;

endpackage

>>> rtl/core/cfd_ram.sv
// Generic single-port-write, registered-read RAM.
module cfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

>>> rtl/core/cfd_queue.sv
// Central task FIFO: head, tail and count over two descriptor RAMs.
module cfd_queue
   import cfd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  logic [HANDLE_W-1:0] push_handles,
   input  logic [ATTR_W-1:0]   push_attrs,
   input  logic                pop,
   output logic                full,
   output logic                empty,
   output logic [HANDLE_W-1:0] head_handles,
   output logic [ATTR_W-1:0]   head_attrs
);
   logic [QA_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [QC_W-1:0] count_ff, count_in;

   assign full  = (count_ff == QC_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push && !full) begin
         tail_in  = (tail_ff == QA_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
         count_in = count_ff + 1'b1;
      end else if (pop && !empty) begin
         head_in  = (head_ff == QA_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   cfd_ram #(.WIDTH(HANDLE_W), .DEPTH(QUEUE_DEPTH)) u_handles (
      .clock(clock), .wr_en(push && !full), .wr_addr(tail_ff), .wr_data(push_handles),
      .rd_addr(head_ff), .rd_data(head_handles)
   );

   cfd_ram #(.WIDTH(ATTR_W), .DEPTH(QUEUE_DEPTH)) u_attrs (
      .clock(clock), .wr_en(push && !full), .wr_addr(tail_ff), .wr_data(push_attrs),
      .rd_addr(head_ff), .rd_data(head_attrs)
   );

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QC_W'(QUEUE_DEPTH)) else $error("queue count overflow");
   a_pop_moves_head: assert property (@(posedge clock) disable iff (reset)
      (pop && !empty && !push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("pop lost");
   a_full_holds_tail: assert property (@(posedge clock) disable iff (reset)
      (push && full) |=> $stable(tail_ff)) else $error("push into full queue");
`endif
endmodule

>>> rtl/core/cfd_age.sv
// Shared run-time unit: elapsed time of one slot against the preempt delay.
module cfd_age
   import cfd_pkg::*;
(
   input  logic [62:0] now,
   input  logic [62:0] started,
   input  logic [31:0] delay,
   output logic        overdue
);
   logic [62:0] elapsed;

   assign elapsed = now - started;
   assign overdue = elapsed > {31'b0, delay};
endmodule

>>> rtl/core/central_fifo_task_dispatcher_core.sv
// Top level of the central FIFO task dispatcher.
// An arrival or report item is accepted in ST_IDLE and finishes in ST_FLUSH. A scan item
// visits the scanned slots (workers_in_use, saturated at the slot count) one per
// cycle while no dispatch or result stall holds it; each dispatch adds a queue RAM
// read state (ST_READ) and a dispatch state (ST_DISP) before the next slot.
// Results leave through one pending stage and an output register; the final
// result of an item carries last.
module central_fifo_task_dispatcher_core
   import cfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   state_type state_ff, state_in;
   logic [3:0]  workers_ff, workers_in;
   logic        enable_ff, enable_in;
   logic [31:0] delay_ff, delay_in;
   logic [WORKER_SLOTS-1:0] busy_ff, busy_in, armed_ff, armed_in;
   logic [62:0] started_ff [WORKER_SLOTS];
   logic [62:0] started_in [WORKER_SLOTS];
   logic [SLOT_CW-1:0] slot_ff, slot_in, lim;
   logic [62:0] now_ff, now_in;
   logic    pend_valid_ff, pend_valid_in, rsp_valid_ff, rsp_valid_in;
   rsp_type pend_ff, pend_in, rsp_ff, rsp_in, cand;
   logic    accept, out_free, produce_ok, in_range, overdue, slot_busy;
   logic    q_push, q_pop, q_full, q_empty;
   logic [HANDLE_W-1:0] q_handles;
   logic [ATTR_W-1:0]   q_attrs;
   logic [SLOT_W-1:0]   sidx, widx;

   assign csr_ready  = 1'b1;
   assign req_stall  = (state_ff != ST_IDLE);
   assign accept     = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign produce_ok = !pend_valid_ff || out_free;
   assign sidx       = slot_ff[SLOT_W-1:0];
   assign widx       = req_data.worker_id[SLOT_W-1:0];
   assign in_range   = slot_ff < lim;
   assign slot_busy  = busy_ff[sidx];
   assign lim = (int'(workers_ff) > WORKER_SLOTS) ? SLOT_CW'(WORKER_SLOTS)
                                                  : SLOT_CW'(workers_ff);

   cfd_age u_age (
      .now(now_ff), .started(started_ff[sidx]), .delay(delay_ff), .overdue(overdue)
   );

   cfd_queue u_queue (
      .clock(clock), .reset(reset), .push(q_push),
      .push_handles({req_data.task_handle, req_data.buffer_handle}),
      .push_attrs({req_data.task_type, req_data.task_category}),
      .pop(q_pop), .full(q_full), .empty(q_empty),
      .head_handles(q_handles), .head_attrs(q_attrs)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_data.cmd == CMD_SCAN) ? ST_SLOT : ST_FLUSH;
            end
         end
         ST_SLOT: begin
            if (!in_range) begin
               state_in = ST_FLUSH;
            end else if (!slot_busy && !q_empty) begin
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_DISP;
         ST_DISP: begin
            if (produce_ok) begin
               state_in = ST_SLOT;
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff || out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      workers_in    = workers_ff;
      enable_in     = enable_ff;
      delay_in      = delay_ff;
      busy_in       = busy_ff;
      armed_in      = armed_ff;
      started_in    = started_ff;
      slot_in       = slot_ff;
      now_in        = now_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;
      q_push        = 1'b0;
      q_pop         = 1'b0;
      cand          = '0;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_WORKERS_IN_USE: workers_in = csr_data[3:0];
            CSR_PREEMPT_ENABLE: enable_in  = csr_data[0];
            CSR_PREEMPT_DELAY:  delay_in   = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cand.out_task   = req_data.task_handle;
               cand.out_buffer = req_data.buffer_handle;
               unique case (req_data.cmd)
                  CMD_ARRIVAL: begin
                     q_push = 1'b1;
                     if (q_full) begin
                        cand.kind         = KIND_DROPPED;
                        cand.out_type     = req_data.task_type;
                        cand.out_category = req_data.task_category;
                        pend_valid_in     = 1'b1;
                     end
                  end
                  CMD_FINISHED, CMD_PREEMPTED: begin
                     if (int'(req_data.worker_id) < WORKER_SLOTS && busy_ff[widx]) begin
                        busy_in[widx]   = 1'b0;
                        armed_in[widx]  = 1'b0;
                        cand.out_worker = req_data.worker_id;
                        if (req_data.cmd == CMD_FINISHED) begin
                           cand.kind     = KIND_RELEASE;
                           pend_valid_in = 1'b1;
                        end else begin
                           q_push = 1'b1;
                           if (q_full) begin
                              cand.kind         = KIND_DROPPED;
                              cand.out_type     = req_data.task_type;
                              cand.out_category = req_data.task_category;
                              pend_valid_in     = 1'b1;
                           end
                        end
                     end
                  end
                  CMD_SCAN: begin
                     slot_in = '0;
                     now_in  = req_data.now;
                  end
                  default: ;
               endcase
               pend_in = cand;
            end
         end
         ST_SLOT: begin
            if (in_range) begin
               if (!slot_busy) begin
                  if (q_empty) begin
                     slot_in = slot_ff + 1'b1;
                  end
               end else if (enable_ff && armed_ff[sidx] && overdue) begin
                  if (produce_ok) begin
                     cand.kind        = KIND_PREEMPT;
                     cand.out_worker  = 3'(slot_ff);
                     cand.start_stamp = started_ff[sidx];
                     if (pend_valid_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = pend_ff;
                        rsp_in.last  = 1'b0;
                     end
                     pend_valid_in  = 1'b1;
                     pend_in        = cand;
                     armed_in[sidx] = 1'b0;
                     slot_in        = slot_ff + 1'b1;
                  end
               end else begin
                  slot_in = slot_ff + 1'b1;
               end
            end
         end
         ST_READ: ;
         ST_DISP: begin
            if (produce_ok) begin
               cand.kind         = KIND_DISPATCH;
               cand.out_worker   = 3'(slot_ff);
               cand.out_task     = q_handles[63:32];
               cand.out_buffer   = q_handles[31:0];
               cand.out_type     = q_attrs[18:3];
               cand.out_category = q_attrs[2:0];
               cand.start_stamp  = now_ff;
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = pend_ff;
                  rsp_in.last  = 1'b0;
               end
               pend_valid_in    = 1'b1;
               pend_in          = cand;
               q_pop            = 1'b1;
               busy_in[sidx]    = 1'b1;
               armed_in[sidx]   = 1'b1;
               started_in[sidx] = now_ff;
               slot_in          = slot_ff + 1'b1;
            end
         end
         ST_FLUSH: begin
            if (pend_valid_ff && out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_in        = pend_ff;
               rsp_in.last   = 1'b1;
               pend_valid_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         workers_ff    <= 4'd8;
         enable_ff     <= 1'b0;
         delay_ff      <= '1;
         busy_ff       <= '0;
         armed_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < WORKER_SLOTS; i++) begin
            started_ff[i] <= '1;
         end
      end else begin
         state_ff      <= state_in;
         workers_ff    <= workers_in;
         enable_ff     <= enable_in;
         delay_ff      <= delay_in;
         busy_ff       <= busy_in;
         armed_ff      <= armed_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         started_ff    <= started_in;
      end
      slot_ff <= slot_in;
      now_ff  <= now_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

`ifndef ASSERT_OFF
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff) else $error("pending item left in idle");
   a_disp_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DISP) |-> !q_empty) else $error("dispatch from empty queue");
   a_armed_busy: assert property (@(posedge clock) disable iff (reset)
      (armed_ff & ~busy_ff) == '0) else $error("armed idle worker");
`endif
endmodule

>>> dv/tb.sv
// Self-checking testbench for the central FIFO task dispatcher core.
module tb;
   import cfd_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 400;
   localparam logic [62:0] STAMP_MAX = {63{1'b1}};

   typedef struct packed {
      logic [31:0] task_handle;
      logic [31:0] buffer_handle;
      logic [15:0] task_type;
      logic [2:0]  task_category;
   } task_desc_type;

   typedef struct {
      bit            is_csr;
      logic [1:0]    idx;
      logic [31:0]   wdata;
      req_type       item;
      bit            typed;
      bit            has_rsp;
      rsp_type       rsp;
   } row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic [1:0]  csr_index;
   logic [31:0] csr_data;

   central_fifo_task_dispatcher_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // dispatcher mirror
   task_desc_type task_q[$];
   bit            slot_busy [WORKER_SLOTS];
   logic [62:0]   slot_start [WORKER_SLOTS];
   bit            slot_armed [WORKER_SLOTS];
   logic [3:0]    cfg_workers;
   bit            cfg_preempt;
   logic [31:0]   cfg_delay;

   rsp_type pending_q[$];
   int      n_errors;
   int      n_items;
   int      n_results;
   int      kind_seen [4];
   int      burst_left;
   bit      hold_req;
   int      hold_cnt;
   int      stall_mode;
   int      mode_left;
   int      idle_cycles;
   logic [62:0] clock_now;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      n_errors++;
      $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
   endtask

   function automatic rsp_type make_rsp(kind_type k, logic [2:0] w, logic [31:0] t,
                                        logic [31:0] b, logic [15:0] ty,
                                        logic [2:0] c, logic [62:0] s);
      rsp_type r;
      r.kind = k;
      r.out_worker = w;
      r.out_task = t;
      r.out_buffer = b;
      r.out_type = ty;
      r.out_category = c;
      r.start_stamp = s;
      r.last = 1'b0;
      return r;
   endfunction

   function automatic void dispatch_step(input req_type it, output rsp_type res[$]);
      task_desc_type d;
      int lim;
      res = {};
      d.task_handle = it.task_handle;
      d.buffer_handle = it.buffer_handle;
      d.task_type = it.task_type;
      d.task_category = it.task_category;
      case (cmd_type'(it.cmd))
         CMD_ARRIVAL: begin
            if (task_q.size() >= QUEUE_DEPTH)
               res.push_back(make_rsp(KIND_DROPPED, 3'd0, d.task_handle, d.buffer_handle,
                                      d.task_type, d.task_category, '0));
            else
               task_q.push_back(d);
         end
         CMD_FINISHED, CMD_PREEMPTED: begin
            if (slot_busy[it.worker_id]) begin
               slot_busy[it.worker_id] = 0;
               slot_armed[it.worker_id] = 0;
               if (it.cmd == CMD_FINISHED)
                  res.push_back(make_rsp(KIND_RELEASE, it.worker_id, d.task_handle,
                                         d.buffer_handle, '0, '0, '0));
               else if (task_q.size() >= QUEUE_DEPTH)
                  res.push_back(make_rsp(KIND_DROPPED, it.worker_id, d.task_handle,
                                         d.buffer_handle, d.task_type, d.task_category,
                                         '0));
               else
                  task_q.push_back(d);
            end
         end
         default: begin
            lim = (cfg_workers > WORKER_SLOTS) ? WORKER_SLOTS : cfg_workers;
            for (int s = 0; s < lim; s++) begin
               if (!slot_busy[s]) begin
                  if (task_q.size() > 0) begin
                     d = task_q.pop_front();
                     slot_busy[s] = 1;
                     slot_armed[s] = 1;
                     slot_start[s] = it.now;
                     res.push_back(make_rsp(KIND_DISPATCH, s[2:0], d.task_handle,
                                            d.buffer_handle, d.task_type,
                                            d.task_category, it.now));
                  end
               end else if (cfg_preempt && slot_armed[s] &&
                            (it.now - slot_start[s]) > {31'd0, cfg_delay}) begin
                  slot_armed[s] = 0;
                  res.push_back(make_rsp(KIND_PREEMPT, s[2:0], '0, '0, '0, '0,
                                         slot_start[s]));
               end
            end
         end
      endcase
      if (res.size() > 0)
         res[res.size() - 1].last = 1'b1;
   endfunction

   task automatic send_item(input req_type it, input bit typed, input bit has_rsp,
                            input rsp_type typed_rsp);
      rsp_type res[$];
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            @(negedge clock);
            req_valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      @(negedge clock);
      req_valid = 1'b1;
      req_data = it;
      do @(posedge clock); while (req_stall);
      dispatch_step(it, res);
      n_items++;
      if (typed) begin
         if (has_rsp) pending_q.push_back(typed_rsp);
      end else begin
         foreach (res[i]) pending_q.push_back(res[i]);
      end
   endtask

   task automatic drain_results;
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [31:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_WORKERS_IN_USE: cfg_workers = value[3:0];
         CSR_PREEMPT_ENABLE: cfg_preempt = value[0];
         CSR_PREEMPT_DELAY:  cfg_delay = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic req_type make_req(cmd_type c, logic [2:0] w, logic [31:0] t,
                                        logic [31:0] b, logic [15:0] ty,
                                        logic [2:0] cat, logic [62:0] stamp);
      req_type r;
      r.cmd = c;
      r.worker_id = w;
      r.task_handle = t;
      r.buffer_handle = b;
      r.task_type = ty;
      r.task_category = cat;
      r.now = stamp;
      return r;
   endfunction

   function automatic req_type random_req(int arrival_pct);
      req_type r;
      int pick;
      int busy_list[$];
      r.task_handle = $urandom;
      r.buffer_handle = $urandom;
      r.task_type = 16'($urandom);
      r.task_category = 3'($urandom);
      r.worker_id = 3'($urandom);
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 19) == 0)
         clock_now = 63'({$urandom, $urandom});
      else
         clock_now = clock_now + $urandom_range(0, 60);
      r.now = clock_now;
      if (pick < arrival_pct) begin
         r.cmd = CMD_ARRIVAL;
      end else if (pick < arrival_pct + (100 - arrival_pct) / 2) begin
         r.cmd = ($urandom_range(0, 1) == 0) ? CMD_FINISHED : CMD_PREEMPTED;
         for (int s = 0; s < WORKER_SLOTS; s++)
            if (slot_busy[s]) busy_list.push_back(s);
         if (busy_list.size() > 0 && $urandom_range(0, 9) < 8)
            r.worker_id = 3'(busy_list[$urandom_range(0, busy_list.size() - 1)]);
      end else begin
         r.cmd = CMD_SCAN;
      end
      return r;
   endfunction

   // result side: stall pattern and long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall = 1'b0;
      end else if (hold_cnt > 0) begin
         rsp_stall = 1'b1;
         hold_cnt--;
      end else if (hold_req) begin
         hold_req = 1'b0;
         hold_cnt = HOLD_CYCLES;
         rsp_stall = 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 120);
         end
         mode_left--;
         case (stall_mode)
            0: rsp_stall = 1'b0;
            1: rsp_stall = ($urandom_range(0, 9) < 3);
            2: rsp_stall = ($urandom_range(0, 9) < 7);
            default: rsp_stall = (mode_left % 4 == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         n_results++;
         if (pending_q.size() == 0) begin
            report_mismatch("unexpected result", 64'(rsp_data.kind), '0);
         end else begin
            want = pending_q.pop_front();
            kind_seen[want.kind]++;
            if (rsp_data.kind != want.kind)
               report_mismatch("kind", rsp_data.kind, want.kind);
            if (rsp_data.out_worker != want.out_worker)
               report_mismatch("out_worker", rsp_data.out_worker, want.out_worker);
            if (rsp_data.out_task != want.out_task)
               report_mismatch("out_task", rsp_data.out_task, want.out_task);
            if (rsp_data.out_buffer != want.out_buffer)
               report_mismatch("out_buffer", rsp_data.out_buffer, want.out_buffer);
            if (rsp_data.out_type != want.out_type)
               report_mismatch("out_type", rsp_data.out_type, want.out_type);
            if (rsp_data.out_category != want.out_category)
               report_mismatch("out_category", rsp_data.out_category, want.out_category);
            if (rsp_data.start_stamp != want.start_stamp)
               report_mismatch("start_stamp", rsp_data.start_stamp, want.start_stamp);
            if (rsp_data.last !== want.last)
               report_mismatch("last", rsp_data.last, want.last);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired at %0t with %0d results outstanding", $time,
                  pending_q.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      row_type rows[$];
      row_type row;
      rsp_type none;
      int n_phase_items;
      int fill_count;

      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      hold_req = 1'b0;
      hold_cnt = 0;
      mode_left = 0;
      stall_mode = 0;
      burst_left = 0;
      idle_cycles = 0;
      n_errors = 0;
      n_items = 0;
      n_results = 0;
      clock_now = '0;
      none = '0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
      cfg_workers = 4'd8;
      cfg_preempt = 1'b0;
      cfg_delay = 32'hFFFF_FFFF;
      for (int s = 0; s < WORKER_SLOTS; s++) begin
         slot_busy[s] = 0;
         slot_armed[s] = 0;
         slot_start[s] = STAMP_MAX;
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table
      row = '{default: '0};
      row.item = make_req(CMD_SCAN, 3'd0, '0, '0, '0, '0, 63'd0);
      row.typed = 1;
      rows.push_back(row);
      row = '{default: '0};
      row.item = make_req(CMD_FINISHED, 3'd3, 32'h1, 32'h2, '0, '0, '0);
      row.typed = 1;
      rows.push_back(row);
      row = '{default: '0};
      row.item = make_req(CMD_ARRIVAL, 3'd7, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 3'd7,
                          STAMP_MAX);
      row.typed = 1;
      rows.push_back(row);
      row = '{default: '0};
      row.item = make_req(CMD_ARRIVAL, 3'd0, 32'h0, 32'hFFFF_FFFF, 16'h0, 3'd0, '0);
      rows.push_back(row);
      row.item = make_req(CMD_ARRIVAL, 3'd5, 32'hA5A5_5A5A, 32'h1234_5678, 16'h8001,
                          3'd4, 63'd9);
      rows.push_back(row);
      row.item = make_req(CMD_SCAN, 3'd0, '0, '0, '0, '0, 63'd100);
      rows.push_back(row);
      row = '{default: '0};
      row.item = make_req(CMD_FINISHED, 3'd0, 32'hDEAD_BEEF, 32'hCAFE_F00D, 16'h7777,
                          3'd5, '0);
      row.typed = 1;
      row.has_rsp = 1;
      row.rsp = make_rsp(KIND_RELEASE, 3'd0, 32'hDEAD_BEEF, 32'hCAFE_F00D, '0, '0, '0);
      row.rsp.last = 1'b1;
      rows.push_back(row);
      row = '{default: '0};
      row.item = make_req(CMD_PREEMPTED, 3'd1, 32'h0BAD_CAFE, 32'h0000_0001, 16'h0002,
                          3'd3, '0);
      rows.push_back(row);
      row.item = make_req(CMD_SCAN, 3'd0, '0, '0, '0, '0, STAMP_MAX);
      rows.push_back(row);
      row = '{default: '0};
      row.item = make_req(CMD_FINISHED, 3'd7, '0, '0, '0, '0, '0);
      row.typed = 1;
      rows.push_back(row);
      row = '{default: '0};
      row.is_csr = 1;
      row.idx = CSR_PREEMPT_ENABLE;
      row.wdata = 32'hFFFF_FFFF;
      rows.push_back(row);
      row.idx = CSR_PREEMPT_DELAY;
      row.wdata = 32'h0;
      rows.push_back(row);
      row = '{default: '0};
      row.item = make_req(CMD_SCAN, 3'd0, '0, '0, '0, '0, 63'd5);
      rows.push_back(row);
      row.item = make_req(CMD_SCAN, 3'd0, '0, '0, '0, '0, 63'd6);
      row.typed = 1;
      rows.push_back(row);
      row = '{default: '0};
      row.item = make_req(CMD_PREEMPTED, 3'd2, 32'h1111_2222, 32'h3333_4444, 16'h5555,
                          3'd6, '0);
      rows.push_back(row);
      row = '{default: '0};
      row.is_csr = 1;
      row.idx = CSR_WORKERS_IN_USE;
      row.wdata = 32'h0;
      rows.push_back(row);
      row = '{default: '0};
      row.item = make_req(CMD_SCAN, 3'd0, '0, '0, '0, '0, 63'd7);
      row.typed = 1;
      rows.push_back(row);
      row = '{default: '0};
      row.is_csr = 1;
      row.idx = CSR_WORKERS_IN_USE;
      row.wdata = 32'hFFFF_FFFF;
      rows.push_back(row);
      row = '{default: '0};
      row.item = make_req(CMD_SCAN, 3'd0, '0, '0, '0, '0, 63'd8);
      rows.push_back(row);
      row = '{default: '0};
      row.is_csr = 1;
      row.idx = CSR_PREEMPT_DELAY;
      row.wdata = 32'hFFFF_FFFF;
      rows.push_back(row);
      row = '{default: '0};
      row.item = make_req(CMD_FINISHED, 3'd1, 32'h5, 32'h6, '0, '0, '0);
      rows.push_back(row);
      row.item = make_req(CMD_PREEMPTED, 3'd0, 32'h7, 32'h8, 16'h9, 3'd1, '0);
      rows.push_back(row);
      row.item = make_req(CMD_SCAN, 3'd0, '0, '0, '0, '0, 63'h4000_0000_0000_0000);
      rows.push_back(row);

      foreach (rows[i]) begin
         if (rows[i].is_csr) begin
            drain_results();
            csr_write(csr_index_type'(rows[i].idx), rows[i].wdata);
         end else begin
            send_item(rows[i].item, rows[i].typed, rows[i].has_rsp, rows[i].rsp);
         end
      end
      drain_results();

      // random phases over several settings
      for (int ph = 0; ph < 7; ph++) begin
         drain_results();
         case (ph)
            0: begin
               csr_write(CSR_WORKERS_IN_USE, 32'h8);
               csr_write(CSR_PREEMPT_ENABLE, 32'h0);
            end
            1: begin
               csr_write(CSR_PREEMPT_ENABLE, $urandom | 32'h1);
               csr_write(CSR_PREEMPT_DELAY, 32'h0);
            end
            2: begin
               csr_write(CSR_WORKERS_IN_USE, 32'h3);
               csr_write(CSR_PREEMPT_DELAY, 32'd20);
            end
            3: begin
               csr_write(CSR_WORKERS_IN_USE, {28'($urandom_range(0, 15)), 4'd1});
               csr_write(CSR_PREEMPT_DELAY, $urandom_range(0, 150));
            end
            4: begin
               csr_write(CSR_WORKERS_IN_USE, 32'h0);
            end
            5: begin
               csr_write(CSR_WORKERS_IN_USE, 32'hF);
               csr_write(CSR_PREEMPT_DELAY, 32'hFFFF_FFFF);
            end
            default: begin
               csr_write(CSR_WORKERS_IN_USE, 32'h8);
               csr_write(CSR_PREEMPT_DELAY, 32'd30);
            end
         endcase
         n_phase_items = (ph == 4) ? 15 : 60;
         if (ph == 6) begin
            // fill the task queue until arrivals drop
            fill_count = QUEUE_DEPTH - task_q.size() + 6;
            for (int k = 0; k < fill_count; k++) begin
               row.item = random_req(100);
               send_item(row.item, 1'b0, 1'b0, none);
            end
         end
         for (int k = 0; k < n_phase_items; k++) begin
            if (ph == 2 && k == 10) hold_req = 1'b1;
            row.item = random_req((ph == 6) ? 20 : 35);
            send_item(row.item, 1'b0, 1'b0, none);
         end
      end
      drain_results();

      $display("Covered %0d items and %0d results over seven register settings", n_items,
               n_results);
      $display("Dispatch %0d, release %0d, preempt %0d, dropped %0d", kind_seen[0],
               kind_seen[1], kind_seen[2], kind_seen[3]);
      if (n_errors == 0 && pending_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches, %0d results outstanding", n_errors, pending_q.size());
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
